// ----- rtl/core/ssh_pkg.sv -----
// ----------------------------------------------------------------------------
// ssh_pkg
// Shared types and constants for the symbol slot hash block.
// ----------------------------------------------------------------------------
package ssh_pkg;

  // hash constants
  localparam logic [31:0] MULT_SEED   = 32'hC613_FC15;
  localparam logic [31:0] MULT_FACTOR = 32'h5BD1_E995;
  localparam logic [31:0] JENK_SEED   = 32'h0000_0000;

  // configuration register indexes
  localparam logic CFG_HASH_SELECT  = 1'b0;
  localparam logic CFG_RESERVED_LOW = 1'b1;

  // hash_select codes
  localparam logic HASH_MULT    = 1'b0;
  localparam logic HASH_JENKINS = 1'b1;

  // configuration reset values
  localparam logic        HASH_SELECT_RST  = HASH_JENKINS;
  localparam logic [11:0] RESERVED_LOW_RST = 12'd2;

  // field widths
  localparam int CHAR_W = 8;
  localparam int HASH_W = 32;
  localparam int SLOT_W = 12;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_FINISH
  } back_state_t;

endpackage

// ----- rtl/core/symbol_slot_hash.sv -----
// ----------------------------------------------------------------------------
// symbol_slot_hash
// Symbol name hash with hash-table slot reduction.
// ----------------------------------------------------------------------------
// Usage:
//   Characters of a name arrive one per word on the in_ channel, with
//   in_last_char set on the final one. Each character is hashed in the
//   cycle it is accepted, so a name streams in at one character a cycle
//   while in_stall is low. On the last character the finished hash
//   enters a four-word queue. The back end takes one word from the queue
//   and forms the remainder by the usable range one bit per cycle, in a
//   load step, the divide steps and a finish step; it takes another
//   word only after the finish step has moved the result to out_. The
//   front keeps hashing until the queue fills, and then raises in_stall.
//   The cfg_ channel writes hash_select (index 0) and reserved_low
//   (index 1); cfg_ready is always high.
//   Reset (rst_n low, synchronous) restores the register defaults, clears
//   the queue and the output, and starts a new name.
//   While out_stall is high the result is held and the back end waits,
//   after which the queue and then in_stall back up.
// ----------------------------------------------------------------------------
module symbol_slot_hash #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // character channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_exact_case,
  input  logic        in_last_char,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_slot_index,
  output logic [31:0] out_raw_hash,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int SW = $clog2(TABLE_ENTRIES);
  localparam int QW = ssh_pkg::HASH_W + 2 * SW;

  ssh_pkg::q_status_t q_status;
  logic               q_push, q_pop;
  logic [QW-1:0]      q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // hashing front
  ssh_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_code  (in_char_code),
    .in_exact_case (in_exact_case),
    .in_last_char  (in_last_char),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_status      (q_status),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  // decoupling queue
  ssh_queue #(
    .W     (QW),
    .DEPTH (4)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  // reducing back end
  ssh_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot_index (out_slot_index),
    .out_raw_hash   (out_raw_hash)
  );

endmodule

// ----- rtl/core/ssh_front.sv -----
// ----------------------------------------------------------------------------
// ssh_front
// Per-character hash update and name-end classification; pushes finished
// hashes with their reduction range into the queue.
// ----------------------------------------------------------------------------
module ssh_front #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // character channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ssh_pkg::CHAR_W-1:0]  in_char_code,
  input  logic                        in_exact_case,
  input  logic                        in_last_char,
  // configuration
  input  logic                        cfg_valid,
  input  logic                        cfg_index,
  input  logic [11:0]                 cfg_data,
  // queue side
  input  ssh_pkg::q_status_t          q_status,
  output logic                        q_push,
  output logic [ssh_pkg::HASH_W+2*$clog2(TABLE_ENTRIES)-1:0] q_wdata
);

  localparam int          SW       = $clog2(TABLE_ENTRIES);
  localparam logic [31:0] RMAX     = 32'(TABLE_ENTRIES - 4);
  localparam logic [31:0] SPAN_TOP = 32'(TABLE_ENTRIES - 3);

  logic        hash_sel_r;
  logic [11:0] rsv_r;
  logic [31:0] run_r, run_nxt;
  logic        start_r;

  logic        accept;
  logic [7:0]  ch;
  logic [31:0] h0;
  logic [31:0] j1, j2, j3;
  logic [31:0] m_in, m_prod, m_out;
  logic [31:0] hc;
  logic [31:0] f1, f2, f3;
  logic [31:0] hf;
  logic [31:0] rsv_ext, rsat32, span32;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_sel_r <= ssh_pkg::HASH_SELECT_RST;
      rsv_r      <= ssh_pkg::RESERVED_LOW_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssh_pkg::CFG_HASH_SELECT:  hash_sel_r <= cfg_data[0];
        ssh_pkg::CFG_RESERVED_LOW: rsv_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall only on a full queue
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  // case folding of a-z
  always_comb begin
    ch = in_char_code;
    if (!in_exact_case && in_char_code >= 8'h61 && in_char_code <= 8'h7A) begin
      ch = in_char_code - 8'h20;
    end
  end

  // starting value
  always_comb begin
    if (start_r) begin
      h0 = (hash_sel_r == ssh_pkg::HASH_JENKINS) ? ssh_pkg::JENK_SEED
                                                 : ssh_pkg::MULT_SEED;
    end else begin
      h0 = run_r;
    end
  end

  // one-at-a-time character step
  always_comb begin
    j1 = h0 + {24'd0, ch};
    j2 = j1 + (j1 << 10);
    j3 = j2 ^ (j2 >> 6);
  end

  // multiply character step
  always_comb begin
    m_in   = h0 ^ {24'd0, ch};
    m_prod = m_in * ssh_pkg::MULT_FACTOR;
    m_out  = m_prod ^ (m_prod >> 15);
  end

  assign hc = (hash_sel_r == ssh_pkg::HASH_JENKINS) ? j3 : m_out;

  // final mix for one-at-a-time, fed from the one-at-a-time step only
  always_comb begin
    f1 = j3 + (j3 << 3);
    f2 = f1 ^ (f1 >> 11);
    f3 = f2 + (f2 << 15);
  end

  assign hf = (hash_sel_r == ssh_pkg::HASH_JENKINS) ? f3 : hc;

  // reduction range with saturated reserved count
  always_comb begin
    rsv_ext = {20'd0, rsv_r};
    rsat32  = (rsv_ext > RMAX) ? RMAX : rsv_ext;
    span32  = SPAN_TOP - rsat32;
  end

  assign run_nxt = in_last_char ? hf : hc;

  // running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 32'd0;
      start_r <= 1'b1;
    end else if (accept) begin
      run_r   <= run_nxt;
      start_r <= in_last_char;
    end
  end

  // push finished word
  assign q_push  = accept && in_last_char;
  assign q_wdata = {hf, span32[SW-1:0], rsat32[SW-1:0]};

endmodule

// ----- rtl/core/ssh_queue.sv -----
// ----------------------------------------------------------------------------
// ssh_queue
// Short register queue between the hashing front and the reducing back.
// ----------------------------------------------------------------------------
module ssh_queue #(
  parameter int W     = 56,
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [W-1:0]       wdata,
  input  logic               pop,
  output logic [W-1:0]       rdata,
  output ssh_pkg::q_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rdata        = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/ssh_back.sv -----
// ----------------------------------------------------------------------------
// ssh_back
// Bit-serial remainder of the hash by the usable range, slot offset and
// output register.
// ----------------------------------------------------------------------------
module ssh_back #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // queue side
  input  ssh_pkg::q_status_t          q_status,
  input  logic [ssh_pkg::HASH_W+2*$clog2(TABLE_ENTRIES)-1:0] q_rdata,
  output logic                        q_pop,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ssh_pkg::SLOT_W-1:0]  out_slot_index,
  output logic [ssh_pkg::HASH_W-1:0]  out_raw_hash
);

  localparam int SW = $clog2(TABLE_ENTRIES);

  ssh_pkg::back_state_t state_r, state_nxt;

  logic [31:0]  shift_r, raw_r;
  logic [SW-1:0] span_r, rsat_r, rem_r;
  logic [4:0]   cnt_r;
  logic         load_out;
  logic         out_valid_r;
  logic [11:0]  out_slot_r;
  logic [31:0]  out_raw_r;

  logic [SW:0]   trial, diff;
  logic          ge;
  logic [SW-1:0] rem_nxt;
  logic [31:0]   slot_sum;

  // next state and handshakes
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ssh_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          state_nxt = ssh_pkg::BK_DIVIDE;
        end
      end
      ssh_pkg::BK_DIVIDE: begin
        if (cnt_r == 5'd31) begin
          state_nxt = ssh_pkg::BK_FINISH;
        end
      end
      ssh_pkg::BK_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ssh_pkg::BK_IDLE;
        end
      end
      default: state_nxt = ssh_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssh_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // one remainder bit per cycle, msb first
  always_comb begin
    trial   = {rem_r, shift_r[31]};
    diff    = trial - {1'b0, span_r};
    ge      = (trial >= {1'b0, span_r});
    rem_nxt = ge ? diff[SW-1:0] : trial[SW-1:0];
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      shift_r <= q_rdata[2*SW +: 32];
      raw_r   <= q_rdata[2*SW +: 32];
      span_r  <= q_rdata[SW +: SW];
      rsat_r  <= q_rdata[0 +: SW];
      rem_r   <= '0;
      cnt_r   <= '0;
    end else if (state_r == ssh_pkg::BK_DIVIDE) begin
      shift_r <= {shift_r[30:0], 1'b0};
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_r + 5'd1;
    end
  end

  // slot offset above the reserved range
  assign slot_sum = 32'(rem_r) + 32'(rsat_r) + 32'd1;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_slot_r <= slot_sum[11:0];
      out_raw_r  <= raw_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot_index = out_slot_r;
  assign out_raw_hash   = out_raw_r;

endmodule

// ----- rtl/core/ssh_checker.sv -----
// ----------------------------------------------------------------------------
// ssh_checker
// Port-level checks of the symbol slot hash block.
// ----------------------------------------------------------------------------
module ssh_checker #(
  parameter int TABLE_ENTRIES = 4096
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_slot_index,
  input logic [31:0] out_raw_hash
);

  // a stalled result stays valid
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its word
  a_out_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_slot_index) && $stable(out_raw_hash))
    else $error("stalled result changed");

  // reset leaves no result and the input not stalled
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

  // slot zero is never produced for tables that fit twelve bits
  a_slot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_slot_index != 12'd0) || (TABLE_ENTRIES > 4096))
    else $error("slot index zero");

endmodule

bind symbol_slot_hash ssh_checker #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_ssh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_slot_index (out_slot_index),
  .out_raw_hash   (out_raw_hash)
);
